/* design/bil_pkg.sv */
// ---------------------------------------------------------------------------
// bil_pkg
// Shared widths, codes and types of the bounded indexed list unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bil_pkg;

    localparam int DEPTH    = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Fixed field widths of the stream items.
    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 7;
    localparam int CFG_W    = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - (ST_W + VAL_W + LEN_W);

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(DEPTH);

    localparam logic [OP_W-1:0] OP_APPEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ      = 2'd1;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
    } result_t;

endpackage

`default_nettype wire

/* design/bil_mem.sv */
// ---------------------------------------------------------------------------
// bil_mem
// Entry store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bil_mem
    import bil_pkg::*;
(
    input  wire logic              aclk,
    input  wire mem_req_t          req,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] store [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= store[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/bil_ctrl.sv */
// ---------------------------------------------------------------------------
// bil_ctrl
// Request sequencer: checks each request, drives the entry store and walks
// the compaction loop of a delete one word per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bil_ctrl
    import bil_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [OP_W-1:0]     req_opcode,
    input  wire logic [POS_W-1:0]    req_position,
    input  wire logic [VAL_W-1:0]    req_entry_value,
    input  wire logic                out_free,
    output logic                     res_valid,
    output result_t                  res,
    output mem_req_t                 mem_req,
    input  wire logic [DATA_W-1:0]   mem_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOVE = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CFG_W-1:0]  max_entries_reg;
    logic [ST_W-1:0]   status_reg, status_next;
    logic              is_read_reg, is_read_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  pos_ext;
    logic              accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end else if (cfg_valid) begin
            max_entries_reg <= cfg_data;
        end
    end

    // The limit in force never exceeds the store depth.
    always_comb begin
        if (max_entries_reg > CFG_W'(DEPTH)) begin
            limit = CNT_W'(DEPTH);
        end else begin
            limit = CNT_W'(max_entries_reg);
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign pos_ext   = CNT_W'(req_position);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        is_read_next = is_read_reg;
        idx_next     = idx_reg;
        mem_req      = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next  = ST_OK;
                    is_read_next = 1'b0;
                    state_next   = S_DONE;
                    if (req_opcode == OP_APPEND) begin
                        if (count_reg >= limit) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = count_reg[ADDR_W-1:0];
                            mem_req.wr_data = req_entry_value[DATA_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else if (pos_ext >= count_reg) begin
                        status_next = ST_BEYOND;
                    end else begin
                        case (req_opcode)
                            OP_READ: begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = req_position[ADDR_W-1:0];
                                is_read_next    = 1'b1;
                            end
                            OP_OVERWRITE: begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = req_position[ADDR_W-1:0];
                                mem_req.wr_data = req_entry_value[DATA_W-1:0];
                            end
                            default: begin
                                // Delete: prefetch the successor, then shift down; a last entry just drops off.
                                if (pos_ext + CNT_W'(1) < count_reg) begin
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = req_position[ADDR_W-1:0]
                                                      + ADDR_W'(1);
                                    idx_next        = req_position[ADDR_W-1:0];
                                    state_next      = S_MOVE;
                                end else begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        endcase
                    end
                end
            end
            S_MOVE: begin
                // The word read last cycle belongs one place lower.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rd_data;
                if (CNT_W'(idx_reg) + CNT_W'(2) < count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg + ADDR_W'(2);
                    idx_next        = idx_reg + ADDR_W'(1);
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        is_read_reg <= is_read_next;
        idx_reg     <= idx_next;
    end

    assign res_valid      = (state_reg == S_DONE);
    assign res.status     = status_reg;
    assign res.read_value = is_read_reg ? VAL_W'(mem_rd_data) : '0;
    assign res.length     = LEN_W'(count_reg);

endmodule

`default_nettype wire

/* design/bounded_indexed_list_unit.sv */
// Append, overwrite, read and refused requests are decided when accepted; the result
// waits in the sequencer's done state, then moves into the output register. A delete
// at position p first walks the compaction loop one word per cycle while entries
// follow p, moving them down one place. The block takes no new request until the
// current one has moved into the output register.
// Reset clears the length and output valid, sets max_entries to 64, not the store.
// ---------------------------------------------------------------------------
// bounded_indexed_list_unit
// Ordered list with append, indexed read, overwrite and delete.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_unit
    import bil_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration: max_entries.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // Requests.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] opcode, [7:2] position, [39:8] entry_value
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // Results.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [33:2] read_value, [40:34] length, [47:41] zero
    output logic [M_DATA_W-1:0]       m_tdata
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rd_data;
    logic              res_valid;
    result_t           res;
    logic              out_free;

    logic              m_tvalid_reg;
    result_t           m_res_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    bil_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_opcode      (s_tdata[1:0]),
        .req_position    (s_tdata[7:2]),
        .req_entry_value (s_tdata[39:8]),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res),
        .mem_req         (mem_req),
        .mem_rd_data     (mem_rd_data)
    );

    bil_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Output register: a finished result waits here for the downstream side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.length, m_res_reg.read_value,
                       m_res_reg.status};

endmodule

`default_nettype wire

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded indexed list unit. Requests are sent
// over the input stream and every accepted request is run through a
// behavioral list model. Each result transaction is compared field by field
// with the oldest predicted result. Several list limits are tried: the reset
// value, zero, one, a limit below the current length, the largest code, and
// random values. Both stream sides idle at random, and one long receiver
// stall backs the block up.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bil_pkg::*;

    // Shadow copy of the list and its limit. Predicted results are queued in
    // request order.
    class list_scoreboard;
        logic [DATA_W-1:0] entries [DEPTH];
        int unsigned       count;
        int unsigned       peak;
        logic [CFG_W-1:0]  limit_reg;
        result_t           pending [$];
        int unsigned       errors;
        int unsigned       requests;
        int unsigned       status_seen [4];

        function void reset_state();
            count     = 0;
            peak      = 0;
            limit_reg = MAX_ENTRIES_RESET;
            pending.delete();
        endfunction

        function void set_limit(logic [CFG_W-1:0] value);
            limit_reg = value;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] val);
            result_t     res;
            int unsigned cap;
            cap = (limit_reg > DEPTH) ? DEPTH : limit_reg;
            res.status     = ST_OK;
            res.read_value = '0;
            if (op == OP_APPEND) begin
                if (count >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    entries[count] = val[DATA_W-1:0];
                    count++;
                end
            end else if (count == 0) begin
                res.status = ST_EMPTY;
            end else if (pos >= count) begin
                res.status = ST_BEYOND;
            end else begin
                case (op)
                    OP_READ: begin
                        res.read_value = entries[pos];
                    end
                    OP_OVERWRITE: begin
                        entries[pos] = val[DATA_W-1:0];
                    end
                    default: begin
                        // Later entries move down one place to close the gap.
                        for (int i = pos; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                    end
                endcase
            end
            res.length = LEN_W'(count);
            if (count > peak)
                peak = count;
            requests++;
            status_seen[res.status]++;
            pending.push_back(res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            result_t want;
            if (pending.size() == 0) begin
                $error("result transaction with no request outstanding: %h", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (word[ST_W-1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, word[ST_W-1:0]);
                errors++;
            end
            if (word[ST_W +: VAL_W] !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value,
                       word[ST_W +: VAL_W]);
                errors++;
            end
            if (word[ST_W+VAL_W +: LEN_W] !== want.length) begin
                $error("length: expected %0d, got %0d", want.length,
                       word[ST_W+VAL_W +: LEN_W]);
                errors++;
            end
            if (word[ST_W+VAL_W+LEN_W +: M_PAD_W] !== '0) begin
                $error("pad: expected 0, got %h", word[ST_W+VAL_W+LEN_W +: M_PAD_W]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    list_scoreboard sb = new();
    int send_idle_pct  = 0;
    int sink_idle_pct  = 0;
    int hold_request   = 0;
    int phase_hold     = 0;
    int stall_left     = 0;
    int limit_writes   = 0;

    bounded_indexed_list_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Result side: check every result transaction, then decide whether the
    // next cycle stalls. A requested long hold overrides the random bursts.
    always begin
        @(posedge aclk);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end else if (stall_left == 0 && sink_idle_pct > 0 &&
                     $urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(1, 15);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        s_tdata  <= {val, pos, op};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_request(op, pos, val);
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
    endtask

    // The limit is only changed with the block idle.
    task automatic write_limit(input logic [CFG_W-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
        limit_writes++;
    endtask

    task automatic random_request(input int append_pct);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        if ($urandom_range(0, 99) < append_pct) begin
            op = OP_APPEND;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = OP_READ;
                1:       op = OP_OVERWRITE;
                default: op = OP_DELETE;
            endcase
        end
        // Mostly valid positions, with some anywhere in the field's range.
        if (sb.count > 0 && $urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, sb.count - 1));
        else
            pos = POS_W'($urandom_range(0, 63));
        send_request(op, pos, $urandom());
    endtask

    // A long receiver hold starts only after the limit write, so that the
    // sender keeps offering requests while the result side is held off.
    task automatic run_phase(input logic [CFG_W-1:0] lim, input int append_pct,
                             input int n_items);
        write_limit(lim);
        if (phase_hold != 0) begin
            hold_request = phase_hold;
            phase_hold   = 0;
        end
        for (int k = 0; k < n_items; k++) begin
            random_request(append_pct);
            if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                sender_gap();
            else if ($urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 20;
        sink_idle_pct = 10;

        // Directed part: empty list, extremes of the data, positions at and
        // past the end, shifting deletes, then tiny and zero limits.
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_OVERWRITE, 6'd5, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 6'd63, 32'h0);
        send_request(OP_APPEND, 6'd63, 32'h0000_0000);
        send_request(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
        send_request(OP_APPEND, 6'd21, 32'hA5A5_A5A5);
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_READ, 6'd1, 32'h0);
        send_request(OP_READ, 6'd3, 32'h0);
        send_request(OP_READ, 6'd63, 32'h0);
        send_request(OP_OVERWRITE, 6'd2, 32'h5A5A_5A5A);
        send_request(OP_READ, 6'd2, 32'h0);
        send_request(OP_DELETE, 6'd0, 32'h0);
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_DELETE, 6'd1, 32'h0);
        send_request(OP_DELETE, 6'd2, 32'h0);
        send_request(OP_OVERWRITE, 6'd1, 32'h1234_5678);
        send_request(OP_DELETE, 6'd0, 32'h0);
        send_request(OP_READ, 6'd0, 32'h0);
        write_limit(7'd1);
        send_request(OP_APPEND, 6'd0, 32'h8000_0001);
        send_request(OP_APPEND, 6'd0, 32'h7FFF_FFFE);
        send_request(OP_READ, 6'd0, 32'h0);
        // Zero limit with one entry still stored.
        write_limit(7'd0);
        send_request(OP_APPEND, 6'd0, 32'hDEAD_BEEF);
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_DELETE, 6'd0, 32'h0);
        send_request(OP_APPEND, 6'd0, 32'hDEAD_BEEF);

        // Fill to the full depth; the long hold at the start backs the block up
        // while requests keep coming.
        send_idle_pct = 0;
        phase_hold    = 300;
        run_phase(7'd64, 70, 300);
        send_idle_pct = 15;
        sink_idle_pct = 15;
        run_phase(7'd5, 40, 150);
        send_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(7'd127, 55, 250);
        send_idle_pct = 25;
        sink_idle_pct = 25;
        run_phase(7'd64, 15, 150);
        for (int r = 0; r < 4; r++) begin
            send_idle_pct = $urandom_range(0, 30);
            sink_idle_pct = $urandom_range(0, 30);
            run_phase(7'($urandom_range(1, 64)), 50, 100);
        end
        // Closing stretch with neither side idling.
        send_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(7'd64, 60, 200);

        drain();
        repeat (70) @(posedge aclk);

        $display("tb: %0d requests, %0d ok, %0d full, %0d empty, %0d beyond length",
                 sb.requests, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_BEYOND]);
        $display("tb: %0d limit writes, longest list %0d entries", limit_writes, sb.peak);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
